[rtl/core/lift_preset_pid_controller_assert.svh]
// Assertion macros for the checker file of the lift preset controller.
`ifndef LIFT_PRESET_PID_CONTROLLER_ASSERT_SVH
`define LIFT_PRESET_PID_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPC_ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lift preset controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPC_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lift preset controller check failed");

`endif

[rtl/core/lpc_pkg.sv]
package lpc_pkg;

    localparam int GAIN_BITS       = 16;
    localparam int PRESET_BITS     = 12;
    localparam int KICK_COUNT_BITS = 3;
    localparam int CMD_BITS        = 3;
    localparam int REG_INDEX_BITS  = 3;
    localparam int PADDR_BITS      = 5;
    localparam int PDATA_BITS      = 32;

    localparam logic signed [7:0] DRIVE_UP   = 8'sd127;
    localparam logic signed [7:0] DRIVE_DOWN = -8'sd127;
    localparam logic [6:0]        DRIVE_MAX  = 7'd127;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_NONE        = 3'd0,
        CMD_RAISE       = 3'd1,
        CMD_LOWER       = 3'd2,
        CMD_SEEK_HIGH   = 3'd3,
        CMD_SEEK_MID    = 3'd4,
        CMD_SEEK_MIDLOW = 3'd5,
        CMD_SEEK_LOW    = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_SEEK = 3'b010,
        MODE_KICK = 3'b100
    } mode_t;

    localparam logic [1:0] SEL_HIGH   = 2'd0;
    localparam logic [1:0] SEL_MID    = 2'd1;
    localparam logic [1:0] SEL_MIDLOW = 2'd2;
    localparam logic [1:0] SEL_LOW    = 2'd3;

    localparam logic [REG_INDEX_BITS-1:0] REG_GAIN_P        = 3'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_GAIN_I        = 3'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_GAIN_D        = 3'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_PRESET_HIGH   = 3'd3;
    localparam logic [REG_INDEX_BITS-1:0] REG_PRESET_MID    = 3'd4;
    localparam logic [REG_INDEX_BITS-1:0] REG_PRESET_MIDLOW = 3'd5;
    localparam logic [REG_INDEX_BITS-1:0] REG_PRESET_LOW    = 3'd6;
    localparam logic [REG_INDEX_BITS-1:0] REG_STOP_BAND     = 3'd7;

    localparam logic [GAIN_BITS-1:0]   GAIN_P_RESET        = 16'd2458;
    localparam logic [GAIN_BITS-1:0]   GAIN_I_RESET        = 16'd4915;
    localparam logic [GAIN_BITS-1:0]   GAIN_D_RESET        = 16'd31;
    localparam logic [PRESET_BITS-1:0] PRESET_HIGH_RESET   = 12'd2670;
    localparam logic [PRESET_BITS-1:0] PRESET_MID_RESET    = 12'd2200;
    localparam logic [PRESET_BITS-1:0] PRESET_MIDLOW_RESET = 12'd2130;
    localparam logic [PRESET_BITS-1:0] PRESET_LOW_RESET    = 12'd1200;
    localparam logic [PRESET_BITS-1:0] STOP_BAND_RESET     = 12'd30;

endpackage

[rtl/core/lpc_sample_if.sv]
interface lpc_sample_if #(
    parameter int POSITION_BITS = 12
) ();
    logic                     valid;
    logic                     ready;
    logic [2:0]               command;
    logic                     abort;
    logic [POSITION_BITS-1:0] position;

    modport source (output valid, command, abort, position, input ready);
    modport sink (input valid, command, abort, position, output ready);
endinterface

[rtl/core/lpc_motor_if.sv]
interface lpc_motor_if ();
    logic              valid;
    logic              ready;
    logic signed [7:0] drive;
    logic              brake_hold;
    logic              busy_res;

    modport source (output valid, drive, brake_hold, busy_res, input ready);
    modport sink (input valid, drive, brake_hold, busy_res, output ready);
endinterface

[rtl/core/lift_preset_pid_controller.sv]
// Lift preset PID controller. One sample item per control tick gives one motor item. The block
// accepts an item in every cycle unless a stalled motor side has filled its stages. The item
// is registered; then the error, the integral and the mode are updated and the three gain
// products are registered; then the products are summed, scaled and saturated into the output
// register. Each stage holds while the stage after it is full and stalled, so an item is still
// accepted while a finished result waits to be taken. Registers are written and read on the
// APB-style port at byte address 4*index; write them only while no item is in flight.
module lift_preset_pid_controller #(
    parameter int KICK_TICKS     = 5,
    parameter int POSITION_BITS  = 12,
    parameter int INTEGRAL_BITS  = 24,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lpc_sample_if.sink                        sample,
    lpc_motor_if.source                       motor,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpc_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [lpc_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [lpc_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready
);
    import lpc_pkg::*;

    localparam int EW   = ((POSITION_BITS > PRESET_BITS) ? POSITION_BITS : PRESET_BITS) + 1;
    localparam int DW   = EW + 1;
    localparam int SW   = ((INTEGRAL_BITS > EW) ? INTEGRAL_BITS : EW) + 1;
    localparam int PPW  = EW + GAIN_BITS + 1;
    localparam int IPW  = INTEGRAL_BITS + GAIN_BITS + 1;
    localparam int DPW  = DW + GAIN_BITS + 1;
    localparam int ACCW = ((IPW > DPW) ? IPW : DPW) + 2;

    localparam logic signed [INTEGRAL_BITS-1:0] I_MAX = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
    localparam logic signed [INTEGRAL_BITS-1:0] I_MIN = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};
    localparam logic [KICK_COUNT_BITS-1:0] KICK_LOAD = KICK_COUNT_BITS'(KICK_TICKS);

    logic [GAIN_BITS-1:0]   gain_p_reg, gain_i_reg, gain_d_reg;
    logic [PRESET_BITS-1:0] preset_high_reg, preset_mid_reg, preset_midlow_reg, preset_low_reg;
    logic [PRESET_BITS-1:0] stop_band_reg;
    logic                   cfg_write;

    logic                     s1_valid_reg;
    logic [CMD_BITS-1:0]      cmd_reg;
    logic                     abort_reg;
    logic [POSITION_BITS-1:0] position_reg;

    mode_t                           mode_reg, mode_next;
    logic [1:0]                      target_reg, target_next;
    logic signed [INTEGRAL_BITS-1:0] integral_reg, integral_next;
    logic signed [EW-1:0]            prev_error_reg, prev_error_next;
    logic [KICK_COUNT_BITS-1:0]      kick_count_reg, kick_count_next;
    logic                            hold_reg, hold_next;

    logic                  s2_valid_reg;
    logic                  pid_sel_reg, pid_sel_next;
    logic signed [7:0]     fixed_drive_reg, fixed_drive_next;
    logic                  hold_s2_reg, busy_s2_reg;
    logic signed [PPW-1:0] prod_p_reg, prod_p_next;
    logic signed [IPW-1:0] prod_i_reg, prod_i_next;
    logic signed [DPW-1:0] prod_d_reg, prod_d_next;

    logic              out_valid_reg;
    logic signed [7:0] drive_reg, drive_next;
    logic              brake_reg, busy_reg;

    logic out_en, s2_en, s1_en, s1_move;

    logic [1:0]                      pid_sel_target;
    logic [PRESET_BITS-1:0]          target_value;
    logic signed [EW-1:0]            err;
    logic [EW-1:0]                   err_mag;
    logic signed [INTEGRAL_BITS-1:0] integral_base, integral_pid;
    logic signed [SW-1:0]            integral_sum;
    logic signed [EW-1:0]            prev_base;
    logic signed [DW-1:0]            diff;
    logic                            run_pid, seek_done;
    logic [KICK_COUNT_BITS-1:0]      kick_left;

    logic signed [ACCW-1:0] acc;
    logic [ACCW-1:0]        acc_mag, acc_shift;
    logic [6:0]             drive_mag;

    assign out_en  = !out_valid_reg || motor.ready;
    assign s2_en   = !s2_valid_reg || out_en;
    assign s1_en   = !s1_valid_reg || s2_en;
    assign s1_move = s1_valid_reg && s2_en;

    assign sample.ready = s1_en;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg        <= GAIN_P_RESET;
            gain_i_reg        <= GAIN_I_RESET;
            gain_d_reg        <= GAIN_D_RESET;
            preset_high_reg   <= PRESET_HIGH_RESET;
            preset_mid_reg    <= PRESET_MID_RESET;
            preset_midlow_reg <= PRESET_MIDLOW_RESET;
            preset_low_reg    <= PRESET_LOW_RESET;
            stop_band_reg     <= STOP_BAND_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[REG_INDEX_BITS+1:2])
                REG_GAIN_P:        gain_p_reg        <= pwdata[GAIN_BITS-1:0];
                REG_GAIN_I:        gain_i_reg        <= pwdata[GAIN_BITS-1:0];
                REG_GAIN_D:        gain_d_reg        <= pwdata[GAIN_BITS-1:0];
                REG_PRESET_HIGH:   preset_high_reg   <= pwdata[PRESET_BITS-1:0];
                REG_PRESET_MID:    preset_mid_reg    <= pwdata[PRESET_BITS-1:0];
                REG_PRESET_MIDLOW: preset_midlow_reg <= pwdata[PRESET_BITS-1:0];
                REG_PRESET_LOW:    preset_low_reg    <= pwdata[PRESET_BITS-1:0];
                REG_STOP_BAND:     stop_band_reg     <= pwdata[PRESET_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[REG_INDEX_BITS+1:2])
            REG_GAIN_P:        prdata = PDATA_BITS'(gain_p_reg);
            REG_GAIN_I:        prdata = PDATA_BITS'(gain_i_reg);
            REG_GAIN_D:        prdata = PDATA_BITS'(gain_d_reg);
            REG_PRESET_HIGH:   prdata = PDATA_BITS'(preset_high_reg);
            REG_PRESET_MID:    prdata = PDATA_BITS'(preset_mid_reg);
            REG_PRESET_MIDLOW: prdata = PDATA_BITS'(preset_midlow_reg);
            REG_PRESET_LOW:    prdata = PDATA_BITS'(preset_low_reg);
            REG_STOP_BAND:     prdata = PDATA_BITS'(stop_band_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && sample.valid)
        begin
            cmd_reg      <= sample.command;
            abort_reg    <= sample.abort;
            position_reg <= sample.position;
        end
    end

    // A seek command from idle picks its preset on the same tick as its first PID step.
    always_comb
    begin
        if (mode_reg == MODE_SEEK)
        begin
            pid_sel_target = target_reg;
        end
        else
        begin
            pid_sel_target = 2'(cmd_reg - CMD_SEEK_HIGH);
        end
    end

    always_comb
    begin
        unique case (pid_sel_target)
            SEL_HIGH:   target_value = preset_high_reg;
            SEL_MID:    target_value = preset_mid_reg;
            SEL_MIDLOW: target_value = preset_midlow_reg;
            SEL_LOW:    target_value = preset_low_reg;
            default:    target_value = preset_high_reg;
        endcase
    end

    always_comb
    begin
        err = $signed({{(EW-PRESET_BITS){1'b0}}, target_value})
            - $signed({{(EW-POSITION_BITS){1'b0}}, position_reg});
        err_mag = err[EW-1] ? EW'(-err) : EW'(err);

        integral_base = (mode_reg == MODE_SEEK) ? integral_reg : '0;
        prev_base     = (mode_reg == MODE_SEEK) ? prev_error_reg : '0;

        integral_sum = SW'(integral_base) + SW'(err);
        if (integral_sum > SW'(I_MAX))
        begin
            integral_pid = I_MAX;
        end
        else if (integral_sum < SW'(I_MIN))
        begin
            integral_pid = I_MIN;
        end
        else
        begin
            integral_pid = INTEGRAL_BITS'(integral_sum);
        end
        if (err == '0 || err_mag > EW'(target_value))
        begin
            integral_pid = '0;
        end

        diff = DW'(err) - DW'(prev_base);

        prod_p_next = PPW'(err) * PPW'($signed({1'b0, gain_p_reg}));
        prod_i_next = IPW'(integral_pid) * IPW'($signed({1'b0, gain_i_reg}));
        prod_d_next = DPW'(diff) * DPW'($signed({1'b0, gain_d_reg}));
    end

    always_comb
    begin
        mode_next        = mode_reg;
        target_next      = target_reg;
        integral_next    = integral_reg;
        prev_error_next  = prev_error_reg;
        kick_count_next  = kick_count_reg;
        hold_next        = hold_reg;
        fixed_drive_next = '0;
        run_pid          = 1'b0;
        seek_done        = 1'b0;
        kick_left        = kick_count_reg;

        unique case (mode_reg)
            MODE_IDLE:
            begin
                unique case (cmd_reg)
                    CMD_RAISE:
                    begin
                        fixed_drive_next = DRIVE_UP;
                    end
                    CMD_LOWER:
                    begin
                        fixed_drive_next = DRIVE_DOWN;
                    end
                    CMD_SEEK_HIGH, CMD_SEEK_MID, CMD_SEEK_MIDLOW, CMD_SEEK_LOW:
                    begin
                        mode_next   = MODE_SEEK;
                        target_next = pid_sel_target;
                        run_pid     = 1'b1;
                    end
                    default:
                    begin
                        hold_next = 1'b0;
                    end
                endcase
            end
            MODE_SEEK:
            begin
                if (abort_reg)
                begin
                    seek_done = 1'b1;
                end
                else
                begin
                    run_pid = 1'b1;
                end
            end
            MODE_KICK:
            begin
                if (kick_count_reg != '0)
                begin
                    fixed_drive_next = DRIVE_DOWN;
                    kick_left        = kick_count_reg - KICK_COUNT_BITS'(1);
                end
                kick_count_next = kick_left;
                if (kick_left == '0)
                begin
                    mode_next = MODE_IDLE;
                    hold_next = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (run_pid)
        begin
            integral_next   = integral_pid;
            prev_error_next = err;
            if (err_mag < EW'(stop_band_reg))
            begin
                seek_done = 1'b1;
            end
        end

        // The low preset finishes with a downward kick instead of going straight to hold.
        if (seek_done)
        begin
            if (pid_sel_target == SEL_LOW && KICK_TICKS > 0)
            begin
                mode_next       = MODE_KICK;
                kick_count_next = KICK_LOAD;
            end
            else
            begin
                mode_next = MODE_IDLE;
                hold_next = 1'b1;
            end
        end

        pid_sel_next = run_pid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            target_reg     <= '0;
            integral_reg   <= '0;
            prev_error_reg <= '0;
            kick_count_reg <= '0;
            hold_reg       <= 1'b0;
        end
        else if (s1_move)
        begin
            mode_reg       <= mode_next;
            target_reg     <= target_next;
            integral_reg   <= integral_next;
            prev_error_reg <= prev_error_next;
            kick_count_reg <= kick_count_next;
            hold_reg       <= hold_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            pid_sel_reg     <= pid_sel_next;
            fixed_drive_reg <= fixed_drive_next;
            hold_s2_reg     <= hold_next;
            busy_s2_reg     <= (mode_next != MODE_IDLE);
            prod_p_reg      <= prod_p_next;
            prod_i_reg      <= prod_i_next;
            prod_d_reg      <= prod_d_next;
        end
    end

    // The scaled drive truncates toward zero, so the shift works on the magnitude.
    always_comb
    begin
        acc       = ACCW'(prod_p_reg) + ACCW'(prod_i_reg) + ACCW'(prod_d_reg);
        acc_mag   = acc[ACCW-1] ? ACCW'(-acc) : ACCW'(acc);
        acc_shift = acc_mag >> GAIN_FRAC_BITS;
        drive_mag = (acc_shift > ACCW'(DRIVE_MAX)) ? DRIVE_MAX : acc_shift[6:0];
        if (!pid_sel_reg)
        begin
            drive_next = fixed_drive_reg;
        end
        else if (acc[ACCW-1])
        begin
            drive_next = -$signed({1'b0, drive_mag});
        end
        else
        begin
            drive_next = $signed({1'b0, drive_mag});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s2_valid_reg)
        begin
            drive_reg <= drive_next;
            brake_reg <= hold_s2_reg;
            busy_reg  <= busy_s2_reg;
        end
    end

    assign motor.valid      = out_valid_reg;
    assign motor.drive      = drive_reg;
    assign motor.brake_hold = brake_reg;
    assign motor.busy_res   = busy_reg;

endmodule

[rtl/core/lpc_checker.sv]
`include "lift_preset_pid_controller_assert.svh"

module lpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       motor_valid,
    input logic       motor_ready,
    input logic [7:0] motor_drive,
    input logic       motor_hold,
    input logic       motor_busy_res
);

    logic       motor_stall;
    logic       coast_idle;
    logic       manual_drive;
    logic [9:0] motor_payload;

    assign motor_stall   = motor_valid && !motor_ready;
    assign motor_payload = {motor_drive, motor_hold, motor_busy_res};
    assign coast_idle    = motor_valid && !motor_busy_res && !motor_hold;
    assign manual_drive  = motor_drive == 8'h00 || motor_drive == 8'h7f
                           || motor_drive == 8'h81;

    // A stalled result item keeps its place and its contents.
    `LPC_ASSERT_NEXT(a_motor_hold, clk, rst_n, motor_stall, motor_valid && $stable(motor_payload))

    // Saturation never lets the drive reach the most negative code.
    `LPC_ASSERT_IMPLY(a_drive_range, clk, rst_n, motor_valid, motor_drive != 8'h80)

    // Idle in coast mode comes only from a manual command or no command.
    `LPC_ASSERT_IMPLY(a_coast_drive, clk, rst_n, coast_idle, manual_drive)

endmodule

bind lift_preset_pid_controller lpc_checker u_lpc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .motor_valid    (motor.valid),
    .motor_ready    (motor.ready),
    .motor_drive    (motor.drive),
    .motor_hold     (motor.brake_hold),
    .motor_busy_res (motor.busy_res)
);

[verif/lift_preset_pid_controller_tb.sv]
module lift_preset_pid_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpc_pkg::*;

    localparam int KICK_TICKS     = 5;
    localparam int POSITION_BITS  = 12;
    localparam int INTEGRAL_BITS  = 24;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int NUM_REGS       = 8;
    localparam int LATENCY_WAIT   = 8;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int PRINT_LIMIT    = 100;

    localparam logic [CMD_BITS-1:0] CMD_SPARE = 3'd7;

    localparam longint INTEGRAL_MAX = (longint'(1) <<< (INTEGRAL_BITS - 1)) - 1;
    localparam longint INTEGRAL_MIN = -INTEGRAL_MAX - 1;

    typedef struct {
        logic signed [7:0] drive;
        logic              brake_hold;
        logic              busy_res;
    } motor_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    lpc_sample_if #(.POSITION_BITS(POSITION_BITS)) sample ();
    lpc_motor_if motor ();

    lift_preset_pid_controller #(
        .KICK_TICKS    (KICK_TICKS),
        .POSITION_BITS (POSITION_BITS),
        .INTEGRAL_BITS (INTEGRAL_BITS),
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .motor  (motor),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Controller copy: gains, presets and the loop state at the block's widths.
    logic [GAIN_BITS-1:0]          kp;
    logic [GAIN_BITS-1:0]          ki;
    logic [GAIN_BITS-1:0]          kd;
    logic [PRESET_BITS-1:0]        preset_pos [4];
    logic [PRESET_BITS-1:0]        band;
    mode_t                         lift_mode;
    logic [1:0]                    seek_sel;
    logic signed [INTEGRAL_BITS-1:0] integ;
    logic signed [POSITION_BITS:0] last_err;
    logic [KICK_COUNT_BITS-1:0]    kick_left;
    logic                          hold;

    motor_item_t expected_motor [$];
    int          mismatch_count;
    bit          pacing;
    int          lift_pos;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0)
        begin
            return $urandom_range(6, 40);
        end
        return $urandom_range(0, 2);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    function automatic void reset_controller();
        kp = GAIN_P_RESET;
        ki = GAIN_I_RESET;
        kd = GAIN_D_RESET;
        preset_pos[SEL_HIGH] = PRESET_HIGH_RESET;
        preset_pos[SEL_MID] = PRESET_MID_RESET;
        preset_pos[SEL_MIDLOW] = PRESET_MIDLOW_RESET;
        preset_pos[SEL_LOW] = PRESET_LOW_RESET;
        band = STOP_BAND_RESET;
        lift_mode = MODE_IDLE;
        seek_sel = SEL_HIGH;
        integ = '0;
        last_err = '0;
        kick_left = '0;
        hold = 1'b0;
    endfunction

    function automatic void store_reg(input logic [REG_INDEX_BITS-1:0] index,
                                      input logic [PDATA_BITS-1:0] value);
        case (index)
            REG_GAIN_P:        kp = value[GAIN_BITS-1:0];
            REG_GAIN_I:        ki = value[GAIN_BITS-1:0];
            REG_GAIN_D:        kd = value[GAIN_BITS-1:0];
            REG_PRESET_HIGH:   preset_pos[SEL_HIGH] = value[PRESET_BITS-1:0];
            REG_PRESET_MID:    preset_pos[SEL_MID] = value[PRESET_BITS-1:0];
            REG_PRESET_MIDLOW: preset_pos[SEL_MIDLOW] = value[PRESET_BITS-1:0];
            REG_PRESET_LOW:    preset_pos[SEL_LOW] = value[PRESET_BITS-1:0];
            REG_STOP_BAND:     band = value[PRESET_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [PDATA_BITS-1:0] reg_value(input logic [REG_INDEX_BITS-1:0] index);
        case (index)
            REG_GAIN_P:        return PDATA_BITS'(kp);
            REG_GAIN_I:        return PDATA_BITS'(ki);
            REG_GAIN_D:        return PDATA_BITS'(kd);
            REG_PRESET_HIGH:   return PDATA_BITS'(preset_pos[SEL_HIGH]);
            REG_PRESET_MID:    return PDATA_BITS'(preset_pos[SEL_MID]);
            REG_PRESET_MIDLOW: return PDATA_BITS'(preset_pos[SEL_MIDLOW]);
            REG_PRESET_LOW:    return PDATA_BITS'(preset_pos[SEL_LOW]);
            default:           return PDATA_BITS'(band);
        endcase
    endfunction

    // A finished seek holds the brake, except that the low preset first kicks downward.
    function automatic void finish_seek();
        if (seek_sel == SEL_LOW && KICK_TICKS > 0)
        begin
            lift_mode = MODE_KICK;
            kick_left = KICK_COUNT_BITS'(KICK_TICKS);
        end
        else
        begin
            lift_mode = MODE_IDLE;
            hold = 1'b1;
        end
    endfunction

    function automatic logic signed [7:0] scale_drive(input longint total);
        longint mag;
        mag = (total < 0) ? -total : total;
        mag = mag >> GAIN_FRAC_BITS;
        if (mag > longint'(DRIVE_MAX))
        begin
            mag = longint'(DRIVE_MAX);
        end
        return (total < 0) ? 8'(-mag) : 8'(mag);
    endfunction

    function automatic logic signed [7:0] pid_update(input logic [POSITION_BITS-1:0] pos);
        longint target;
        longint err;
        longint mag;
        longint acc;
        longint diff;
        longint total;
        target = longint'(preset_pos[seek_sel]);
        err = target - longint'(pos);
        mag = (err < 0) ? -err : err;
        acc = longint'(integ) + err;
        if (acc > INTEGRAL_MAX)
        begin
            acc = INTEGRAL_MAX;
        end
        else if (acc < INTEGRAL_MIN)
        begin
            acc = INTEGRAL_MIN;
        end
        if (err == 0 || mag > target)
        begin
            acc = 0;
        end
        integ = acc[INTEGRAL_BITS-1:0];
        diff = err - longint'(last_err);
        last_err = err[POSITION_BITS:0];
        total = err * longint'(kp) + acc * longint'(ki) + diff * longint'(kd);
        if (mag < longint'(band))
        begin
            finish_seek();
        end
        return scale_drive(total);
    endfunction

    function automatic motor_item_t predict_motor(input logic [CMD_BITS-1:0] cmd,
                                                  input logic ab,
                                                  input logic [POSITION_BITS-1:0] pos);
        motor_item_t res;
        res.drive = '0;
        if (lift_mode == MODE_SEEK)
        begin
            if (ab)
            begin
                finish_seek();
            end
            else
            begin
                res.drive = pid_update(pos);
            end
        end
        else if (lift_mode == MODE_KICK)
        begin
            if (kick_left != 0)
            begin
                res.drive = DRIVE_DOWN;
                kick_left--;
            end
            if (kick_left == 0)
            begin
                lift_mode = MODE_IDLE;
                hold = 1'b1;
            end
        end
        else if (cmd == CMD_RAISE)
        begin
            res.drive = DRIVE_UP;
        end
        else if (cmd == CMD_LOWER)
        begin
            res.drive = DRIVE_DOWN;
        end
        else if (cmd >= CMD_SEEK_HIGH && cmd <= CMD_SEEK_LOW)
        begin
            lift_mode = MODE_SEEK;
            seek_sel = 2'(cmd - CMD_SEEK_HIGH);
            integ = '0;
            last_err = '0;
            res.drive = pid_update(pos);
        end
        else
        begin
            hold = 1'b0;
        end
        res.brake_hold = hold;
        res.busy_res = (lift_mode != MODE_IDLE);
        return res;
    endfunction

    task automatic apb_access(input logic is_write, input logic [REG_INDEX_BITS-1:0] index,
                              input logic [PDATA_BITS-1:0] wdata,
                              output logic [PDATA_BITS-1:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= {index, 2'b00};
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic verify_reg(input logic [REG_INDEX_BITS-1:0] index);
        logic [PDATA_BITS-1:0] rdata;
        apb_access(1'b0, index, '0, rdata);
        if (rdata !== reg_value(index))
        begin
            report_mismatch($sformatf("register %0d reads %h, want %h",
                                      index, rdata, reg_value(index)));
        end
    endtask

    task automatic program_reg(input logic [REG_INDEX_BITS-1:0] index,
                               input logic [PDATA_BITS-1:0] value);
        logic [PDATA_BITS-1:0] rdata;
        apb_access(1'b1, index, value, rdata);
        store_reg(index, value);
        verify_reg(index);
    endtask

    // Stops the sample stream and waits until every motor item has come back or DRAIN_LIMIT runs out.
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        sample.valid <= 1'b0;
        while (expected_motor.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    task automatic send_sample(input logic [CMD_BITS-1:0] cmd, input logic ab,
                               input logic [POSITION_BITS-1:0] pos,
                               output motor_item_t want);
        int gap;
        gap = pacing ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            sample.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample.valid <= 1'b1;
        sample.command <= cmd;
        sample.abort <= ab;
        sample.position <= pos;
        do
            @(posedge clk);
        while (!sample.ready);
        want = predict_motor(cmd, ab, pos);
        expected_motor.push_back(want);
    endtask

    // Mostly closed-loop items: the lift position follows the predicted drive, so seeks
    // settle and finish, with random jumps and aborts mixed in.
    task automatic send_random_items(input int count, input int abort_pct);
        logic [CMD_BITS-1:0]      cmd;
        logic                     ab;
        logic [POSITION_BITS-1:0] pos;
        motor_item_t              want;
        int                       pick;
        for (int i = 0; i < count; i++)
        begin
            cmd = CMD_BITS'($urandom_range(0, 7));
            if (lift_mode == MODE_IDLE)
            begin
                pick = $urandom_range(0, 9);
                if (pick <= 5)
                begin
                    cmd = CMD_BITS'(CMD_SEEK_HIGH + $urandom_range(0, 3));
                    if ($urandom_range(0, 1) == 0)
                    begin
                        lift_pos = $urandom_range(0, 4095);
                    end
                end
                else if (pick == 6)
                begin
                    cmd = CMD_RAISE;
                end
                else if (pick == 7)
                begin
                    cmd = CMD_LOWER;
                end
                else if (pick == 8)
                begin
                    cmd = CMD_NONE;
                end
                else
                begin
                    cmd = CMD_SPARE;
                end
            end
            ab = ($urandom_range(0, 99) < abort_pct);
            if ($urandom_range(0, 4) == 0)
            begin
                pos = POSITION_BITS'($urandom_range(0, 4095));
            end
            else
            begin
                pos = POSITION_BITS'(lift_pos);
            end
            send_sample(cmd, ab, pos, want);
            lift_pos = lift_pos + int'(want.drive) / 8 + int'($urandom_range(0, 6)) - 3;
            if (lift_pos < 0)
            begin
                lift_pos = 0;
            end
            else if (lift_pos > 4095)
            begin
                lift_pos = 4095;
            end
        end
    endtask

    task automatic test_reset_registers();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            verify_reg(REG_INDEX_BITS'(i));
        end
    endtask

    task automatic test_directed();
        motor_item_t want;
        send_sample(CMD_NONE, 1'b0, 12'd0, want);
        send_sample(CMD_RAISE, 1'b0, 12'd4095, want);
        send_sample(CMD_LOWER, 1'b0, 12'd0, want);
        send_sample(CMD_SPARE, 1'b0, 12'd2048, want);
        send_sample(CMD_NONE, 1'b1, 12'd100, want);
        // Seek that lands on its target on the very first tick.
        send_sample(CMD_SEEK_HIGH, 1'b0, 12'd2670, want);
        send_sample(CMD_SEEK_MID, 1'b0, 12'd0, want);
        send_sample(CMD_RAISE, 1'b0, 12'd0, want);
        send_sample(CMD_LOWER, 1'b1, 12'd1000, want);
        // Error equal to the stop band keeps seeking; one below it finishes.
        send_sample(CMD_SEEK_MIDLOW, 1'b0, 12'd2100, want);
        send_sample(CMD_NONE, 1'b0, 12'd2101, want);
        // An error larger than the target clears the integral.
        send_sample(CMD_SEEK_LOW, 1'b0, 12'd4095, want);
        send_sample(CMD_NONE, 1'b0, 12'd1210, want);
        for (int i = 0; i < KICK_TICKS; i++)
        begin
            send_sample(CMD_RAISE, 1'b1, POSITION_BITS'(i * 800), want);
        end
        // An aborted low seek still kicks.
        send_sample(CMD_SEEK_LOW, 1'b0, 12'd0, want);
        send_sample(CMD_NONE, 1'b1, 12'd0, want);
        for (int i = 0; i < KICK_TICKS; i++)
        begin
            send_sample(CMD_SEEK_HIGH, 1'b0, 12'd4095, want);
        end
        send_sample(CMD_NONE, 1'b0, 12'd4095, want);
        settle();
    endtask

    task automatic test_register_extremes();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            program_reg(REG_INDEX_BITS'(i), '1);
        end
        send_random_items(40, 5);
        settle();
        // All zero: no drive from the loop, and a seek only ends on abort.
        for (int i = 0; i < NUM_REGS; i++)
        begin
            program_reg(REG_INDEX_BITS'(i), '0);
        end
        send_random_items(40, 10);
        settle();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 5; phase++)
        begin
            pacing = (phase % 2 == 0);
            program_reg(REG_GAIN_P, ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 8191));
            program_reg(REG_GAIN_I, ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 2047));
            program_reg(REG_GAIN_D, ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 8191));
            program_reg(REG_PRESET_HIGH, $urandom_range(0, 4095));
            program_reg(REG_PRESET_MID, $urandom_range(0, 4095));
            program_reg(REG_PRESET_MIDLOW, ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4095));
            program_reg(REG_PRESET_LOW, $urandom_range(0, 4095));
            program_reg(REG_STOP_BAND, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                                    : $urandom_range(1, 150));
            lift_pos = $urandom_range(0, 4095);
            send_random_items(200, 3);
            settle();
        end
        pacing = 1'b1;
    endtask

    always @(posedge clk)
    begin
        motor_item_t want;
        if (rst_n && motor.valid && motor.ready)
        begin
            if (expected_motor.size() == 0)
            begin
                report_mismatch($sformatf("motor item with none expected, drive %0d",
                                          motor.drive));
            end
            else
            begin
                want = expected_motor.pop_front();
                if (motor.drive !== want.drive)
                begin
                    report_mismatch($sformatf("drive %0d, want %0d", motor.drive, want.drive));
                end
                if (motor.brake_hold !== want.brake_hold)
                begin
                    report_mismatch($sformatf("brake_hold %b, want %b",
                                              motor.brake_hold, want.brake_hold));
                end
                if (motor.busy_res !== want.busy_res)
                begin
                    report_mismatch($sformatf("busy_res %b, want %b",
                                              motor.busy_res, want.busy_res));
                end
            end
        end
    end

    initial
    begin
        int run;
        int stall;
        motor.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 12);
            @(negedge clk);
            motor.ready <= 1'b1;
            repeat (run - 1) @(negedge clk);
            stall = pacing ? pick_gap() : 0;
            if (stall > 0)
            begin
                @(negedge clk);
                motor.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("lift_preset_pid_controller: mismatch");
        $finish;
    end

    initial
    begin
        motor_item_t left;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample.valid = 1'b0;
        sample.command = CMD_NONE;
        sample.abort = 1'b0;
        sample.position = '0;
        mismatch_count = 0;
        pacing = 1'b1;
        lift_pos = 2048;
        reset_controller();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_registers();
        test_directed();
        test_register_extremes();
        test_random();

        settle();
        while (expected_motor.size() != 0)
        begin
            left = expected_motor.pop_front();
            report_mismatch($sformatf("motor item never arrived, drive %0d", left.drive));
        end
        if (mismatch_count == 0)
        begin
            $display("lift_preset_pid_controller: match");
        end
        else
        begin
            $display("lift_preset_pid_controller: mismatch");
        end
        $finish;
    end

endmodule
